FILE: design/tsp_pkg.sv
package tsp_pkg;

  // result kinds
  localparam logic [1:0] KIND_POS    = 2'd0;
  localparam logic [1:0] KIND_NEG    = 2'd1;
  localparam logic [1:0] KIND_BORDER = 2'd2;

  // vertex sources for emission and compare
  localparam logic [2:0] SRC_V0 = 3'd0;
  localparam logic [2:0] SRC_V1 = 3'd1;
  localparam logic [2:0] SRC_V2 = 3'd2;
  localparam logic [2:0] SRC_I1 = 3'd3;
  localparam logic [2:0] SRC_I2 = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_AW = 4;
  localparam logic [CFG_AW-1:0] REG_NORMAL_X     = 4'd0;
  localparam logic [CFG_AW-1:0] REG_NORMAL_Y     = 4'd1;
  localparam logic [CFG_AW-1:0] REG_NORMAL_Z     = 4'd2;
  localparam logic [CFG_AW-1:0] REG_PLANE_OFFSET = 4'd3;

  localparam int unsigned MAX_OUT = 11;

  typedef struct packed {
    logic       load;
    logic [1:0] slot;
    logic       dmul;
    logic       dclr;
    logic       dacc;
    logic [1:0] vsel;
    logic [1:0] axis;
    logic       dinit;
    logic [1:0] da;
    logic [1:0] db;
    logic       dstep;
    logic       imul;
    logic       iwr;
    logic [1:0] ia;
    logic [1:0] ib;
    logic       idst;
    logic [2:0] attr;
    logic       cmp;
    logic [2:0] csrc;
    logic       emit;
    logic [2:0] esrc;
    logic [1:0] ekind;
    logic       elast;
  } tsp_cmd_t;

  typedef struct packed {
    logic [2:0] pos;
    logic [2:0] neg;
    logic       same;
    logic       busy;
  } tsp_status_t;

  function automatic logic [1:0] inc3(input logic [1:0] x);
    inc3 = (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

endpackage

FILE: design/tsp_vtx_if.sv
interface tsp_vtx_if #(
  parameter int COORD_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] pos_x;
  logic [COORD_WIDTH-1:0] pos_y;
  logic [COORD_WIDTH-1:0] pos_z;
  logic [COORD_WIDTH-1:0] tex_u;
  logic [COORD_WIDTH-1:0] tex_v;
  logic [COORD_WIDTH-1:0] norm_x;
  logic [COORD_WIDTH-1:0] norm_y;
  logic [COORD_WIDTH-1:0] norm_z;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                output ready);
endinterface

FILE: design/tsp_res_if.sv
interface tsp_res_if #(
  parameter int COORD_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [COORD_WIDTH-1:0] out_pos_x;
  logic [COORD_WIDTH-1:0] out_pos_y;
  logic [COORD_WIDTH-1:0] out_pos_z;
  logic [COORD_WIDTH-1:0] out_tex_u;
  logic [COORD_WIDTH-1:0] out_tex_v;
  logic [COORD_WIDTH-1:0] out_norm_x;
  logic [COORD_WIDTH-1:0] out_norm_y;
  logic [COORD_WIDTH-1:0] out_norm_z;
  logic                   last;

  modport source (output valid, kind, out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
                  out_norm_x, out_norm_y, out_norm_z, last, input ready);
  modport sink (input valid, kind, out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
                out_norm_x, out_norm_y, out_norm_z, last, output ready);
endinterface

FILE: design/tsp_cfg_if.sv
interface tsp_cfg_if #(
  parameter int COORD_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic [3:0]             addr;
  logic [COORD_WIDTH-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

FILE: design/triangle_plane_split_top.sv
// first and second vertex of a triangle are only stored and give no item
// third vertex: distance multiply-accumulate on one multiplier, classify, then per edge
//   crossing a restoring divide for FRAC_BITS quotient bits and interpolation of all eight
//   attributes, a compare and trim step, then one result item per cycle unless the output
//   stalls (3, 6 or 8, or 9 or 11 items); one triangle at a time
// reset: asynchronous active low, clears the vertex count and controller, loads plane regs
module triangle_plane_split_top #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  tsp_vtx_if.sink   vtx_i,
  tsp_res_if.source res_o,
  tsp_cfg_if.sink   cfg_i
);
  import tsp_pkg::*;

  tsp_cmd_t    cmd;
  tsp_status_t status;

  // sequencer: vertex count, distance / divide / interpolate steps and result script
  tsp_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vtx_i.valid),
    .in_ready_o (vtx_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: vertex store, plane regs, shared distance multiplier, interpolation multiplier, restoring divider
  tsp_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vtx_i    (vtx_i),
    .res_o    (res_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

  // never overwrite an item still waiting at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(res_o.valid && !res_o.ready))
    else $error("result item overwritten");

  // after the final item of a triangle the block takes vertices again
  a_back_to_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.elast) |=> vtx_i.ready)
    else $error("not ready after last item");

  // an interpolated attribute is written only right after its multiply
  a_interp_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.iwr |-> $past(cmd.imul))
    else $error("interpolation write without multiply");

endmodule

FILE: design/tsp_datapath.sv
module tsp_datapath #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tsp_vtx_if.sink            vtx_i,
  tsp_res_if.source          res_o,
  tsp_cfg_if.sink            cfg_i,
  input  tsp_pkg::tsp_cmd_t  cmd_i,
  output tsp_pkg::tsp_status_t status_o
);
  import tsp_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = (2 * CW + 2 > 64) ? 64 : 2 * CW + 2;
  localparam int IPW = CW + FRAC_BITS + 2;

  typedef logic [7:0][CW-1:0] vtx_t;

  vtx_t vt_q [3];
  vtx_t iv_q [2];
  logic signed [CW-1:0]   nrm_q [3];
  logic signed [CW-1:0]   off_q;
  logic signed [2*CW-1:0] prod_q;
  logic signed [DW-1:0]   d_q [3];
  logic [DW:0]            den_q;
  logic [DW+1:0]          rem_q;
  logic [FRAC_BITS-1:0]   q_q;
  logic signed [IPW-1:0]  iprod_q;
  logic                   same_q;
  logic                   ov_q;
  logic [1:0]             kind_q;
  logic                   last_q;
  vtx_t                   out_q;

  function automatic vtx_t sel_src(input logic [2:0] s);
    case (s)
      SRC_V0:  sel_src = vt_q[0];
      SRC_V1:  sel_src = vt_q[1];
      SRC_V2:  sel_src = vt_q[2];
      SRC_I1:  sel_src = iv_q[0];
      SRC_I2:  sel_src = iv_q[1];
      default: sel_src = vt_q[0];
    endcase
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
    mag = x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= CW'(64'd1 << FRAC_BITS);
      off_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        REG_NORMAL_X:     nrm_q[0] <= cfg_i.data;
        REG_NORMAL_Y:     nrm_q[1] <= cfg_i.data;
        REG_NORMAL_Z:     nrm_q[2] <= cfg_i.data;
        REG_PLANE_OFFSET: off_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  vtx_t in_v;
  assign in_v[0] = vtx_i.pos_x;
  assign in_v[1] = vtx_i.pos_y;
  assign in_v[2] = vtx_i.pos_z;
  assign in_v[3] = vtx_i.tex_u;
  assign in_v[4] = vtx_i.tex_v;
  assign in_v[5] = vtx_i.norm_x;
  assign in_v[6] = vtx_i.norm_y;
  assign in_v[7] = vtx_i.norm_z;

  // distance operands
  logic signed [CW-1:0] dpos;
  logic signed [CW-1:0] dnrm;
  logic signed [DW-1:0] off_sh;
  always_comb begin
    dpos   = vt_q[cmd_i.vsel][{1'b0, cmd_i.axis}];
    case (cmd_i.axis)
      2'd0:    dnrm = nrm_q[0];
      2'd1:    dnrm = nrm_q[1];
      2'd2:    dnrm = nrm_q[2];
      default: dnrm = '0;
    endcase
    off_sh = DW'(off_q) <<< FRAC_BITS;
  end

  // divider step
  logic [DW+1:0] rsh;
  logic          ge;
  always_comb begin
    rsh = {rem_q[DW:0], 1'b0};
    ge  = (rsh >= {1'b0, den_q});
  end

  // interpolation, rounding constant kept signed so the shift is a floor
  logic signed [CW-1:0]  a0;
  logic signed [CW-1:0]  a1;
  logic signed [CW:0]    diff;
  logic signed [IPW-1:0] isum;
  logic [CW-1:0]         ires;
  logic                  in_rng;
  always_comb begin
    a0     = vt_q[cmd_i.ia][cmd_i.attr];
    a1     = vt_q[cmd_i.ib][cmd_i.attr];
    diff   = (CW+1)'(a1) - (CW+1)'(a0);
    isum   = ((iprod_q + $signed(IPW'(64'd1 << (FRAC_BITS - 1)))) >>> FRAC_BITS)
             + IPW'(a0);
    in_rng = (&isum[IPW-1:CW-1]) | ~(|isum[IPW-1:CW-1]);
    if (in_rng) begin
      ires = isum[CW-1:0];
    end else if (isum[IPW-1]) begin
      ires = {1'b1, {(CW-1){1'b0}}};
    end else begin
      ires = {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) vt_q[cmd_i.slot] <= in_v;
    if (cmd_i.dmul) prod_q <= dpos * dnrm;
    if (cmd_i.dclr) d_q[cmd_i.vsel] <= -off_sh;
    if (cmd_i.dacc) d_q[cmd_i.vsel] <= d_q[cmd_i.vsel] + DW'(prod_q);
    if (cmd_i.dinit) begin
      den_q <= {1'b0, mag(d_q[cmd_i.da])} + {1'b0, mag(d_q[cmd_i.db])};
      rem_q <= {2'b00, mag(d_q[cmd_i.da])};
      q_q   <= '0;
    end
    if (cmd_i.dstep) begin
      rem_q <= ge ? (rsh - {1'b0, den_q}) : rsh;
      q_q   <= {q_q[FRAC_BITS-2:0], ge};
    end
    if (cmd_i.imul) iprod_q <= diff * $signed({1'b0, q_q});
    if (cmd_i.iwr)  iv_q[cmd_i.idst][cmd_i.attr] <= ires;
    if (cmd_i.cmp)  same_q <= (sel_src(SRC_I1) == sel_src(cmd_i.csrc));
    if (cmd_i.emit) begin
      out_q  <= sel_src(cmd_i.esrc);
      kind_q <= cmd_i.ekind;
      last_q <= cmd_i.elast;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (res_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  assign res_o.valid      = ov_q;
  assign res_o.kind       = kind_q;
  assign res_o.last       = last_q;
  assign res_o.out_pos_x  = out_q[0];
  assign res_o.out_pos_y  = out_q[1];
  assign res_o.out_pos_z  = out_q[2];
  assign res_o.out_tex_u  = out_q[3];
  assign res_o.out_tex_v  = out_q[4];
  assign res_o.out_norm_x = out_q[5];
  assign res_o.out_norm_y = out_q[6];
  assign res_o.out_norm_z = out_q[7];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      status_o.neg[i] = d_q[i][DW-1];
      status_o.pos[i] = ~d_q[i][DW-1] & (|d_q[i]);
    end
    status_o.same = same_q;
    status_o.busy = ov_q & ~res_o.ready;
  end

endmodule

FILE: design/tsp_ctrl.sv
module tsp_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tsp_pkg::tsp_status_t status_i,
  output tsp_pkg::tsp_cmd_t    cmd_o
);
  import tsp_pkg::*;

  localparam int CNTW = $clog2(FRAC_BITS + 1);

  localparam logic [2:0] ST_IN   = 3'd0;
  localparam logic [2:0] ST_DIST = 3'd1;
  localparam logic [2:0] ST_CLS  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_INTP = 3'd4;
  localparam logic [2:0] ST_CMP  = 3'd5;
  localparam logic [2:0] ST_TRIM = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0]      st_q, st_d;
  logic [1:0]      vslot_q, vslot_d;
  logic [1:0]      vi_q, vi_d;
  logic [1:0]      ax_q, ax_d;
  logic            ph_q, ph_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [2:0]      attr_q, attr_d;
  logic            ipass_q, ipass_d;
  logic [3:0]      ei_q, ei_d;
  logic [3:0]      ns_q, ns_d;

  // emission script, written once per triangle
  logic [1:0] sk_q [MAX_OUT];
  logic [2:0] ss_q [MAX_OUT];
  logic       bord_q, two_q;
  logic [1:0] ia_q, ib1_q, ib2_q;
  logic [2:0] csrc_q;

  logic [1:0] ck [MAX_OUT];
  logic [2:0] cs [MAX_OUT];
  logic [3:0] cn;
  logic       cbord, ctwo, cint;
  logic [1:0] cia, cib1, cib2;
  logic [2:0] ccsrc;

  // classify corners and build the result script
  always_comb begin
    logic [1:0] np, nn, pi, ni, z, z1, z2, s, s1, s2, kp, kn;
    logic [2:0] zero;
    zero = ~(status_i.pos | status_i.neg);
    np   = {1'b0, status_i.pos[0]} + {1'b0, status_i.pos[1]} + {1'b0, status_i.pos[2]};
    nn   = {1'b0, status_i.neg[0]} + {1'b0, status_i.neg[1]} + {1'b0, status_i.neg[2]};
    pi   = status_i.pos[0] ? 2'd0 : (status_i.pos[1] ? 2'd1 : 2'd2);
    ni   = status_i.neg[0] ? 2'd0 : (status_i.neg[1] ? 2'd1 : 2'd2);
    z    = zero[2] ? 2'd2 : (zero[1] ? 2'd1 : 2'd0);
    z1   = inc3(z);
    z2   = inc3(z1);
    s    = (nn == 2'd1) ? ni : pi;
    s1   = inc3(s);
    s2   = inc3(s1);
    for (int i = 0; i < MAX_OUT; i++) begin
      ck[i] = KIND_POS;
      cs[i] = SRC_V0;
    end
    cn = 4'd3; cbord = 1'b0; ctwo = 1'b0; cint = 1'b0;
    cia = ni; cib1 = pi; cib2 = s2; ccsrc = SRC_I2;
    kp = KIND_POS; kn = KIND_NEG;
    if (nn == 2'd0 || np == 2'd0) begin
      for (int i = 0; i < 3; i++) begin
        ck[i] = (nn == 2'd0) ? KIND_POS : KIND_NEG;
        cs[i] = 3'(i);
      end
    end else if (np == nn) begin
      // one corner on the plane
      if (z1 == pi) begin
        kp = KIND_POS; kn = KIND_NEG;
      end else begin
        kp = KIND_NEG; kn = KIND_POS;
      end
      cint = 1'b1; cbord = 1'b1; cn = 4'd8; ccsrc = {1'b0, z};
      ck[0] = kp; cs[0] = {1'b0, z};
      ck[1] = kp; cs[1] = {1'b0, z1};
      ck[2] = kp; cs[2] = SRC_I1;
      ck[3] = kn; cs[3] = SRC_I1;
      ck[4] = kn; cs[4] = {1'b0, z2};
      ck[5] = kn; cs[5] = {1'b0, z};
      ck[6] = KIND_BORDER; cs[6] = SRC_I1;
      ck[7] = KIND_BORDER; cs[7] = {1'b0, z};
    end else begin
      // plane crosses both edges that meet at s, the lone corner
      cint = 1'b1; ctwo = 1'b1; cbord = 1'b1; cn = 4'd11;
      cia = s; cib1 = s1; cib2 = s2; ccsrc = SRC_I2;
      if (nn == 2'd1) begin
        kp = KIND_NEG; kn = KIND_POS;
        cs[3] = SRC_I1;      cs[4] = {1'b0, s1}; cs[5] = {1'b0, s2};
      end else begin
        kp = KIND_POS; kn = KIND_NEG;
        cs[3] = {1'b0, s1};  cs[4] = {1'b0, s2}; cs[5] = SRC_I1;
      end
      ck[0] = kp; cs[0] = SRC_I1;
      ck[1] = kp; cs[1] = SRC_I2;
      ck[2] = kp; cs[2] = {1'b0, s};
      ck[3] = kn; ck[4] = kn; ck[5] = kn;
      ck[6] = kn; cs[6] = {1'b0, s2};
      ck[7] = kn; cs[7] = SRC_I2;
      ck[8] = kn; cs[8] = SRC_I1;
      ck[9] = KIND_BORDER;  cs[9] = SRC_I2;
      ck[10] = KIND_BORDER; cs[10] = SRC_I1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_CLS) begin
      for (int i = 0; i < MAX_OUT; i++) begin
        sk_q[i] <= ck[i];
        ss_q[i] <= cs[i];
      end
      bord_q <= cbord;
      two_q  <= ctwo;
      ia_q   <= cia;
      ib1_q  <= cib1;
      ib2_q  <= cib2;
      csrc_q <= ccsrc;
    end
  end

  always_comb begin
    logic [3:0] ns_cls;
    st_d = st_q; vslot_d = vslot_q; vi_d = vi_q; ax_d = ax_q; ph_d = ph_q;
    cnt_d = cnt_q; attr_d = attr_q; ipass_d = ipass_q; ei_d = ei_q; ns_d = ns_q;
    ns_cls = cn;
    cmd_o = '0;
    cmd_o.slot  = vslot_q;
    cmd_o.vsel  = vi_q;
    cmd_o.axis  = ax_q;
    cmd_o.da    = ia_q;
    cmd_o.db    = ipass_q ? ib2_q : ib1_q;
    cmd_o.ia    = ia_q;
    cmd_o.ib    = ipass_q ? ib2_q : ib1_q;
    cmd_o.idst  = ipass_q;
    cmd_o.attr  = attr_q;
    cmd_o.csrc  = csrc_q;
    cmd_o.esrc  = ss_q[ei_q];
    cmd_o.ekind = sk_q[ei_q];
    cmd_o.elast = (ei_q == ns_q - 4'd1);
    in_ready_o  = (st_q == ST_IN);
    case (st_q)
      ST_IN: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (vslot_q == 2'd2) begin
            vslot_d = 2'd0;
            st_d = ST_DIST; vi_d = 2'd0; ax_d = 2'd0; ph_d = 1'b0;
          end else begin
            vslot_d = vslot_q + 2'd1;
          end
        end
      end
      ST_DIST: begin
        ph_d = ~ph_q;
        if (!ph_q) begin
          cmd_o.dmul = 1'b1;
          cmd_o.dclr = (ax_q == 2'd0);
        end else begin
          cmd_o.dacc = 1'b1;
          ax_d = inc3(ax_q);
          if (ax_q == 2'd2) begin
            vi_d = vi_q + 2'd1;
            if (vi_q == 2'd2) st_d = ST_CLS;
          end
        end
      end
      ST_CLS: begin
        ns_d = ns_cls; ei_d = '0; ipass_d = 1'b0; cnt_d = '0;
        st_d = cint ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          cmd_o.dinit = 1'b1;
        end else begin
          cmd_o.dstep = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNTW'(FRAC_BITS)) begin
          st_d = ST_INTP; attr_d = '0; ph_d = 1'b0;
        end
      end
      ST_INTP: begin
        ph_d = ~ph_q;
        if (!ph_q) begin
          cmd_o.imul = 1'b1;
        end else begin
          cmd_o.iwr = 1'b1;
          attr_d = attr_q + 3'd1;
          if (attr_q == 3'd7) begin
            if (two_q && !ipass_q) begin
              ipass_d = 1'b1; cnt_d = '0; st_d = ST_DIV;
            end else begin
              st_d = ST_CMP;
            end
          end
        end
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        st_d = ST_TRIM;
      end
      ST_TRIM: begin
        // border pair is dropped when the two vertices match
        if (bord_q && status_i.same) ns_d = ns_q - 4'd2;
        st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.busy) begin
          cmd_o.emit = 1'b1;
          ei_d = ei_q + 4'd1;
          if (ei_q == ns_q - 4'd1) st_d = ST_IN;
        end
      end
      default: st_d = ST_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IN; vslot_q <= '0; vi_q <= '0; ax_q <= '0; ph_q <= 1'b0;
      cnt_q <= '0; attr_q <= '0; ipass_q <= 1'b0; ei_q <= '0; ns_q <= '0;
    end else begin
      st_q <= st_d; vslot_q <= vslot_d; vi_q <= vi_d; ax_q <= ax_d; ph_q <= ph_d;
      cnt_q <= cnt_d; attr_q <= attr_d; ipass_q <= ipass_d; ei_q <= ei_d; ns_q <= ns_d;
    end
  end

endmodule

FILE: tb/triangle_plane_split_top_tb.sv
module triangle_plane_split_top_tb;
  import tsp_pkg::*;

  localparam int CW = 24;
  localparam int FB = 16;

  typedef logic signed [CW-1:0] coord_t;

  // one vertex: pos xyz, tex uv, normal xyz
  typedef struct {
    coord_t a [8];
  } vertex_t;

  typedef struct {
    logic [1:0] kind;
    coord_t     a [8];
    logic       last;
  } corner_item_t;

  logic clk_i;
  logic rst_ni;
  int   fail_count;

  tsp_vtx_if #(.COORD_WIDTH(CW)) vtx_if ();
  tsp_res_if #(.COORD_WIDTH(CW)) res_if ();
  tsp_cfg_if #(.COORD_WIDTH(CW)) cfg_if ();

  triangle_plane_split_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx_if.sink),
    .res_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // plane splitter predictor and the queue of expected result items
  class split_scoreboard;
    longint     nrm_x, nrm_y, nrm_z, offset;
    int         slot;
    vertex_t    held [2];
    corner_item_t pending [$];

    function void reset_state();
      nrm_x = 0; nrm_y = 0; nrm_z = 65536; offset = 0;
      slot = 0;
    endfunction

    function void write_reg(logic [3:0] idx, coord_t val);
      case (idx)
        REG_NORMAL_X:     nrm_x = val;
        REG_NORMAL_Y:     nrm_y = val;
        REG_NORMAL_Z:     nrm_z = val;
        REG_PLANE_OFFSET: offset = val;
        default: ;
      endcase
    endfunction

    function longint plane_dist(vertex_t v);
      longint p0, p1, p2;
      p0 = v.a[0]; p1 = v.a[1]; p2 = v.a[2];
      return p0 * nrm_x + p1 * nrm_y + p2 * nrm_z - (offset <<< FB);
    endfunction

    function vertex_t crossing(vertex_t v0, longint d0, vertex_t v1, longint d1);
      vertex_t r;
      longint unsigned num, den, rem, q;
      longint diff, prod, x, hi, lo;
      num = d0 < 0 ? -d0 : d0;
      den = num + (d1 < 0 ? -d1 : d1);
      rem = num; q = 0;
      for (int i = 0; i < FB; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem -= den;
          q |= 1;
        end
      end
      hi = (64'sd1 <<< (CW - 1)) - 1;
      lo = -hi - 1;
      for (int i = 0; i < 8; i++) begin
        diff = longint'(v1.a[i]) - longint'(v0.a[i]);
        prod = diff * longint'(q) + (64'sd1 <<< (FB - 1));
        x = longint'(v0.a[i]) + (prod >>> FB);
        r.a[i] = coord_t'(x > hi ? hi : (x < lo ? lo : x));
      end
      return r;
    endfunction

    function void push(logic [1:0] kind, vertex_t v);
      corner_item_t e;
      e.kind = kind;
      e.a = v.a;
      e.last = 1'b0;
      pending.insert(pending.size(), e);
    endfunction

    function bit same_vertex(vertex_t x, vertex_t y);
      foreach (x.a[i]) if (x.a[i] !== y.a[i]) return 0;
      return 1;
    endfunction

    function void note_vertex(vertex_t cur);
      vertex_t t [3];
      vertex_t i1, i2;
      longint  d [3];
      int      np, nn, z, pi, ni, s, s1, s2, before_cnt;
      logic [1:0] kp, kn;
      if (slot < 2) begin
        held[slot] = cur;
        slot++;
        return;
      end
      slot = 0;
      t[0] = held[0]; t[1] = held[1]; t[2] = cur;
      np = 0; nn = 0; z = 0; pi = 0; ni = 0;
      before_cnt = pending.size();
      for (int i = 0; i < 3; i++) begin
        d[i] = plane_dist(t[i]);
        if (d[i] > 0) begin
          if (np == 0) pi = i;
          np++;
        end else if (d[i] < 0) begin
          if (nn == 0) ni = i;
          nn++;
        end else z = i;
      end
      if (nn == 0) begin
        for (int i = 0; i < 3; i++) push(KIND_POS, t[i]);
      end else if (np == 0) begin
        for (int i = 0; i < 3; i++) push(KIND_NEG, t[i]);
      end else if (np == nn) begin
        i1 = crossing(t[ni], d[ni], t[pi], d[pi]);
        if ((z + 1) % 3 == pi) begin
          kp = KIND_POS; kn = KIND_NEG;
        end else begin
          kp = KIND_NEG; kn = KIND_POS;
        end
        push(kp, t[z]); push(kp, t[(z + 1) % 3]); push(kp, i1);
        push(kn, i1); push(kn, t[(z + 2) % 3]); push(kn, t[z]);
        if (!same_vertex(i1, t[z])) begin
          push(KIND_BORDER, i1); push(KIND_BORDER, t[z]);
        end
      end else begin
        s = (nn == 1) ? ni : pi;
        s1 = (s + 1) % 3; s2 = (s + 2) % 3;
        i1 = crossing(t[s], d[s], t[s1], d[s1]);
        i2 = crossing(t[s], d[s], t[s2], d[s2]);
        if (nn == 1) begin
          push(KIND_NEG, i1); push(KIND_NEG, i2); push(KIND_NEG, t[s]);
          push(KIND_POS, i1); push(KIND_POS, t[s1]); push(KIND_POS, t[s2]);
          kp = KIND_POS;
        end else begin
          push(KIND_POS, i1); push(KIND_POS, i2); push(KIND_POS, t[s]);
          push(KIND_NEG, t[s1]); push(KIND_NEG, t[s2]); push(KIND_NEG, i1);
          kp = KIND_NEG;
        end
        push(kp, t[s2]); push(kp, i2); push(kp, i1);
        if (!same_vertex(i1, i2)) begin
          push(KIND_BORDER, i2); push(KIND_BORDER, i1);
        end
      end
      if (pending.size() > before_cnt) pending[$].last = 1'b1;
    endfunction

    function void check_item(corner_item_t got);
      corner_item_t exp;
      string names [8];
      names = '{"out_pos_x", "out_pos_y", "out_pos_z", "out_tex_u", "out_tex_v",
                "out_norm_x", "out_norm_y", "out_norm_z"};
      if (pending.size() == 0) begin
        $error("unexpected result item kind %0d", got.kind);
        fail_count++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d actual %0d", exp.kind, got.kind);
        fail_count++;
      end
      foreach (exp.a[i]) if (got.a[i] !== exp.a[i]) begin
        $error("%s: expected %0d actual %0d", names[i], exp.a[i], got.a[i]);
        fail_count++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d actual %0d", exp.last, got.last);
        fail_count++;
      end
    endfunction
  endclass

  split_scoreboard sb;

  // idle profile: 0 none, 1 sender idles, 2 receiver stalls, 3 both light
  int  idle_mode;
  int  hold_off_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #4000000;
    $display("FAIL triangle_plane_split_top");
    $finish;
  end

  function automatic bit sender_idles();
    case (idle_mode)
      1: return $urandom_range(99) < 74;
      3: return $urandom_range(99) < 14;
      default: return 0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      2: return $urandom_range(99) < 74;
      3: return $urandom_range(99) < 14;
      default: return 0;
    endcase
  endfunction

  // receiver: ready changes on the falling edge, items taken on the rising edge
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= rst_ni && !receiver_stalls();
    end
  end

  always @(posedge clk_i) begin
    corner_item_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.kind = res_if.kind;
      got.a = '{res_if.out_pos_x, res_if.out_pos_y, res_if.out_pos_z, res_if.out_tex_u,
                res_if.out_tex_v, res_if.out_norm_x, res_if.out_norm_y, res_if.out_norm_z};
      got.last = res_if.last;
      sb.check_item(got);
    end
  end

  // valid stays high after an item so the next one can follow with no gap
  task automatic send_vertex(vertex_t v);
    while (sender_idles()) begin
      vtx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    vtx_if.valid <= 1'b1;
    {vtx_if.pos_x, vtx_if.pos_y, vtx_if.pos_z, vtx_if.tex_u} <= {v.a[0], v.a[1], v.a[2], v.a[3]};
    {vtx_if.tex_v, vtx_if.norm_x, vtx_if.norm_y, vtx_if.norm_z} <= {v.a[4], v.a[5], v.a[6], v.a[7]};
    do @(posedge clk_i); while (!vtx_if.ready);
    sb.note_vertex(v);
    @(negedge clk_i);
  endtask

  // drop valid, let the block drain, then a quiet gap
  task automatic wait_idle();
    vtx_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, coord_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return coord_t'($urandom);
      1: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
      default: return coord_t'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
    endcase
  endfunction

  function automatic vertex_t rand_vertex(bit wild);
    vertex_t v;
    foreach (v.a[i]) v.a[i] = wild ? coord_t'($urandom) : rand_coord();
    return v;
  endfunction

  // vertex at position z = zq with small x and y and random attributes
  function automatic vertex_t vz(int zq);
    vertex_t v;
    v = rand_vertex(0);
    v.a[0] = coord_t'($signed($urandom_range(0, 65536 * 4)) - 65536 * 2);
    v.a[1] = coord_t'($signed($urandom_range(0, 65536 * 4)) - 65536 * 2);
    v.a[2] = coord_t'(zq);
    return v;
  endfunction

  task automatic send_tri(vertex_t a, vertex_t b, vertex_t c);
    send_vertex(a); send_vertex(b); send_vertex(c);
  endtask

  initial begin
    vertex_t ext;
    int zs [3];
    sb = new();
    sb.reset_state();
    fail_count = 0;
    idle_mode = 0;
    hold_off_cycles = 0;
    rst_ni = 1'b0;
    vtx_if.valid = 1'b0;
    {vtx_if.pos_x, vtx_if.pos_y, vtx_if.pos_z, vtx_if.tex_u} = '0;
    {vtx_if.tex_v, vtx_if.norm_x, vtx_if.norm_y, vtx_if.norm_z} = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.data = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: default plane z = 0, all cases
    send_tri(vz(65536), vz(2 * 65536), vz(3 * 65536));     // all positive
    send_tri(vz(-65536), vz(-5), vz(-65536 * 3));          // all negative
    send_tri(vz(0), vz(0), vz(0));                         // all on the plane
    send_tri(vz(0), vz(65536), vz(-65536));                // corner on plane, next positive
    send_tri(vz(0), vz(-65536), vz(65536));                // corner on plane, next negative
    send_tri(vz(-65536), vz(65536), vz(2 * 65536));        // lone negative corner
    send_tri(vz(65536), vz(-65536), vz(-3 * 65536));       // lone positive corner
    // field extremes, saturating interpolation
    ext.a = '{24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff,
              24'h800000, 24'h7fffff, 24'h800000};
    send_tri(ext, vz(-8388608), vz(8388607));
    wait_idle();

    // normal x, normal y and plane offset at their extremes, normal z at 1
    write_reg(REG_NORMAL_X, 24'h7fffff);
    write_reg(REG_NORMAL_Y, 24'h800000);
    write_reg(REG_NORMAL_Z, 24'h000001);
    write_reg(REG_PLANE_OFFSET, 24'h7fffff);
    for (int k = 0; k < 3; k++) send_tri(rand_vertex(1), rand_vertex(1), rand_vertex(1));
    wait_idle();
    write_reg(REG_PLANE_OFFSET, 24'h800000);
    write_reg(REG_NORMAL_X, 24'h800000);
    write_reg(REG_NORMAL_Y, 24'h7fffff);
    send_tri(rand_vertex(1), rand_vertex(1), rand_vertex(1));
    wait_idle();

    // random phases with plane z = offset and a random plane
    for (int ph = 0; ph < 5; ph++) begin
      idle_mode = ph % 4;
      write_reg(REG_NORMAL_X, ph == 4 ? rand_coord() : coord_t'(0));
      write_reg(REG_NORMAL_Y, ph == 4 ? rand_coord() : coord_t'(0));
      write_reg(REG_NORMAL_Z, ph == 4 ? rand_coord() : coord_t'(65536));
      write_reg(REG_PLANE_OFFSET, coord_t'($signed($urandom_range(0, 4)) - 2));
      if (ph == 1) hold_off_cycles = 400; // block fills and stalls its input
      for (int k = 0; k < 12; k++) begin
        if ($urandom_range(9) < 7) begin
          foreach (zs[i]) zs[i] = $urandom_range(2) == 0 ? int'(sb.offset) :
                                  $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
          send_tri(vz(zs[0]), vz(zs[1]), vz(zs[2]));
        end else begin
          send_tri(rand_vertex($urandom_range(1)), rand_vertex(0), rand_vertex(1));
        end
      end
      // sender pauses until all results are back
      wait_idle();
    end
    idle_mode = 0;
    wait_idle();
    if (fail_count == 0 && sb.pending.size() == 0) begin
      $display("PASS triangle_plane_split_top");
    end else begin
      $display("FAIL triangle_plane_split_top");
    end
    $finish;
  end
endmodule
